// ----- rtl/smsr_pkg.sv -----
`default_nettype none

package smsr_pkg;

  // Generator word and arithmetic widths
  localparam int STATE_W = 31;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = STATE_W + MULT_W;

  typedef logic [STATE_W-1:0] word_t;
  typedef logic [PROD_W-1:0]  prod_t;

  // Lehmer step constants
  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam word_t             LCG_MOD  = 31'h7FFF_FFFF;

  // Largest sample value (fixed form of 1 - 1.2e-7)
  localparam word_t SAMPLE_MAX = 31'd2147483389;

  // Steps run before the table starts filling
  localparam int WARMUP = 8;

endpackage

`default_nettype wire

// ----- rtl/shuffled_minimal_standard_rng_top.sv -----
// Uniform random generator: minimal standard Lehmer generator behind a
// Bays-Durham shuffle table of TABLE_DEPTH entries.
//
// Request channel: req_valid / req_stall with one field, reseed. Each
// transfer asks for one sample; reseed = 1 reloads the state from the seed
// register and refills the table first. Response channel: res_valid /
// res_stall carrying sample (1 .. 2147483389; uniform = sample / (2^31-1)).
// The user writes the seed register through seed_wr_en / seed_wr_data only while idle (no check).
//
// A plain draw runs through S_DIV (slot compare), S_READ (table read) and
// S_OUT (refill), loading the output register once it is free; the next
// request is taken in the following cycle. A fill (first request after reset,
// or reseed) first runs TABLE_DEPTH + 8 Lehmer steps, each through S_FILL_MUL
// and S_FILL_RED and the shared multiply/fold unit.
// One request is handled at a time; req_stall is high while it runs.
//
// Reset clears the state so the next request fills the table; the seed
// register returns to 1. The result sits in an output register; if the
// receiver stalls, it holds there and the block can accept the next
// request, finishing it only once the register is free.
`default_nettype none

module shuffled_minimal_standard_rng_top
  import smsr_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        seed_wr_en,
  input  wire word_t       seed_wr_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        reseed,
  output logic             res_valid,
  input  wire logic        res_stall,
  output word_t            sample
);

  localparam int SW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + WARMUP + 1);
  localparam longint unsigned SLOT_DIV = 1 + (longint'(LCG_MOD) - 1) / TABLE_DEPTH;
  localparam logic [CW-1:0] FILL_STEPS = CW'(TABLE_DEPTH + WARMUP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL_MUL,
    S_FILL_RED,
    S_DIV,
    S_READ,
    S_OUT
  } state_t;

  state_t             state;
  word_t              seed;
  word_t              lehmer_state;
  word_t              last_output;
  logic [SW-1:0]      slot;
  logic [CW-1:0]      cnt;
  word_t              rdata;
  word_t              tbl [TABLE_DEPTH];

  word_t              step_y;
  word_t              seed_fix;
  logic [CW-1:0]      cnt_m1;
  logic [SW-1:0]      slot_eff;
  logic [TABLE_DEPTH:0] slot_ge;
  logic [SW-1:0]      slot_q;
  logic               out_free;
  logic               tbl_we;
  logic [SW-1:0]      tbl_waddr;
  word_t              clamp_y;

  // Shared step unit, always fed from the running state
  smsr_lehmer u_lehmer (
    .clk (clk),
    .x   (lehmer_state),
    .y   (step_y)
  );

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= word_t'(1);
    end else if (seed_wr_en) begin
      seed <= seed_wr_data;
    end
  end

  // Datapath helpers
  always_comb begin
    seed_fix = (seed == '0 || seed == LCG_MOD) ? word_t'(1) : seed;
    cnt_m1   = cnt - CW'(1);
    // quotient never reaches the depth; keep the index in range anyway
    slot_eff = ({1'b0, slot} >= (SW+1)'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH - 1) : slot;
    out_free = !res_valid || !res_stall;
    clamp_y  = (rdata > SAMPLE_MAX) ? SAMPLE_MAX : rdata;
    req_stall = (state != S_IDLE);
  end

  // Slot select: last_output / SLOT_DIV by parallel compares against the
  // constant slot boundaries, then a thermometer-to-index encode
  always_comb begin
    slot_ge    = '0;
    slot_ge[0] = 1'b1;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      slot_ge[k] = (last_output >= word_t'(longint'(k) * longint'(SLOT_DIV)));
    end
    slot_q = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (slot_ge[k] && !slot_ge[k+1]) begin
        slot_q = slot_q | SW'(k);
      end
    end
  end

  // Table write port: fill writes and draw refills
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = slot_eff;
    case (state)
      S_FILL_RED: begin
        tbl_we    = (cnt_m1 < CW'(TABLE_DEPTH));
        tbl_waddr = cnt_m1[SW-1:0];
      end
      S_OUT: begin
        tbl_we    = out_free;
        tbl_waddr = slot_eff;
      end
      default: begin
        tbl_we    = 1'b0;
        tbl_waddr = slot_eff;
      end
    endcase
  end

  // Shuffle table
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= step_y;
    end
    rdata <= tbl[slot_eff];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      lehmer_state <= '0;
      last_output  <= '0;
    end else begin
      // in S_OUT a leaving result is replaced by the next one below
      if (res_valid && !res_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (reseed || last_output == '0) begin
              lehmer_state <= seed_fix;
              cnt          <= FILL_STEPS;
              state        <= S_FILL_MUL;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_FILL_MUL: begin
          state <= S_FILL_RED;
        end
        S_FILL_RED: begin
          lehmer_state <= step_y;
          cnt          <= cnt_m1;
          if (cnt_m1 == '0) begin
            last_output <= step_y;
            state       <= S_DIV;
          end else begin
            state <= S_FILL_MUL;
          end
        end
        // slot from the previous unclamped draw, or from the final fill value
        S_DIV: begin
          slot  <= slot_q;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            last_output  <= rdata;
            lehmer_state <= step_y;
            sample       <= clamp_y;
            res_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smsr_lehmer.sv -----
`default_nettype none

// Shared Lehmer step unit: registered 31x15 multiply, then a
// Mersenne fold (hi + lo) and one conditional subtract of the modulus.
module smsr_lehmer
  import smsr_pkg::*;
(
  input  wire logic  clk,
  input  wire word_t x,
  output word_t      y
);

  prod_t prod;
  logic [STATE_W:0] fold;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod <= PROD_W'(x) * PROD_W'(LCG_MULT);
  end

  // 2^31 == 1 mod (2^31 - 1): add the high part to the low part
  always_comb begin
    fold = (STATE_W+1)'(prod[PROD_W-1:STATE_W]) + (STATE_W+1)'(prod[STATE_W-1:0]);
    if (fold >= (STATE_W+1)'(LCG_MOD)) begin
      y = STATE_W'(fold - (STATE_W+1)'(LCG_MOD));
    end else begin
      y = fold[STATE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smsr_checker.sv -----
`default_nettype none

module smsr_checker
  import smsr_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  req_valid,
  input wire logic  req_stall,
  input wire logic  res_valid,
  input wire logic  res_stall,
  input wire word_t sample
);

  // Samples stay inside the clamped range
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (sample != '0 && sample <= SAMPLE_MAX))
    else $error("sample out of range");

  // A request is worked on alone: no transfer in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while busy");

  // Reset empties the output register and frees the request side
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!res_valid && !req_stall))
    else $error("not idle after reset");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(sample)))
    else $error("stalled result changed");

endmodule

bind shuffled_minimal_standard_rng_top smsr_checker u_smsr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .sample    (sample)
);

`default_nettype wire

// ----- tb/sv/shuffled_minimal_standard_rng_top_test.sv -----
`default_nettype none

module shuffled_minimal_standard_rng_top_test;
  import smsr_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int FILL_STEPS = TABLE_DEPTH + WARMUP;
  localparam longint unsigned MOD64 = 64'd2147483647;
  localparam word_t SLOT_SPAN = word_t'(1 + (MOD64 - 1) / TABLE_DEPTH);
  localparam int RANDOM_PHASES = 8;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT = 2000000;

  // DUT signals
  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  seed_wr_en = 1'b0;
  word_t seed_wr_data = '0;
  logic  req_valid = 1'b0;
  logic  req_stall;
  logic  reseed = 1'b0;
  logic  res_valid;
  logic  res_stall = 1'b0;
  word_t sample;

  // Generator mirror: seed register, Lehmer state, last draw, shuffle table
  word_t seed_cfg;
  word_t gen_state;
  word_t prev_draw;
  word_t shuffle_tbl [TABLE_DEPTH];

  // Requests waiting to go out, and samples waiting to come back
  logic  pending_reseeds [$];
  word_t predicted_samples [$];

  // Driver / receiver pacing
  bit req_busy = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_hold = 0;

  int cycle_cnt = 0;
  int mismatch_cnt = 0;

  shuffled_minimal_standard_rng_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .seed_wr_en  (seed_wr_en),
    .seed_wr_data(seed_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .reseed      (reseed),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .sample      (sample)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a * b mod (2^31 - 1), exact
  function automatic word_t mod_mul(word_t a, word_t b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return word_t'(prod % MOD64);
  endfunction

  // x advanced by 'steps' Lehmer steps (square-and-multiply on the multiplier)
  function automatic word_t lehmer_jump(word_t x, longint unsigned steps);
    word_t acc;
    word_t base;
    longint unsigned e;
    acc = x;
    base = word_t'(LCG_MULT);
    e = steps;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, base);
      base = mod_mul(base, base);
      e = e >> 1;
    end
    return acc;
  endfunction

  // One request: optional table refill, then one shuffled draw
  function automatic word_t predict_sample(logic reseed_bit);
    word_t x;
    word_t y;
    int slot;
    if (reseed_bit || prev_draw == '0) begin
      x = seed_cfg;
      if (x == '0 || x == LCG_MOD) x = word_t'(1);
      for (int n = FILL_STEPS; n > 0; n--) begin
        x = mod_mul(x, word_t'(LCG_MULT));
        if (n - 1 < TABLE_DEPTH) shuffle_tbl[n-1] = x;
      end
      gen_state = x;
      prev_draw = shuffle_tbl[0];
    end
    gen_state = mod_mul(gen_state, word_t'(LCG_MULT));
    slot = int'(prev_draw / SLOT_SPAN);
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    y = shuffle_tbl[slot];
    prev_draw = y;
    shuffle_tbl[slot] = gen_state;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    return y;
  endfunction

  // Request driver: bursts of transfers separated by random gaps
  always @(negedge clk) begin
    if (!req_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reseeds.size() > 0) begin
        reseed <= pending_reseeds.pop_front();
        req_valid <= 1'b1;
        req_busy = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          case ($urandom_range(0, 7))
            0, 1: gap_left = 0;
            2: gap_left = $urandom_range(20, 100);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern: random modes (none, coin flip, mostly stalled, toggle)
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(5, 60);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= 1'($urandom_range(0, 1));
      2: res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= ~res_stall;
    endcase
  end

  // Monitor: mirror config, predict on request transfers, check result transfers
  always @(posedge clk) begin
    word_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst) begin
      seed_cfg = word_t'(1);
      gen_state = '0;
      prev_draw = '0;
      foreach (shuffle_tbl[i]) shuffle_tbl[i] = '0;
    end else begin
      if (seed_wr_en) seed_cfg = seed_wr_data;
      // result side first: a result never belongs to a request taken this cycle
      if (res_valid && !res_stall) begin
        if (predicted_samples.size() == 0) begin
          mismatch_cnt++;
          $error("sample transfer with nothing expected: actual %0d", sample);
        end else begin
          want = predicted_samples.pop_front();
          if (sample !== want) begin
            mismatch_cnt++;
            $error("sample mismatch: expected %0d, actual %0d", want, sample);
          end
        end
      end
      if (req_valid && !req_stall) begin
        predicted_samples.push_back(predict_sample(reseed));
        req_busy = 1'b0;
      end
    end
  end

  // Block until every queued request went out and every sample came back
  task automatic wait_idle();
    while (pending_reseeds.size() != 0 || req_busy || predicted_samples.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_seed(word_t value);
    @(negedge clk);
    seed_wr_en <= 1'b1;
    seed_wr_data <= value;
    @(negedge clk);
    seed_wr_en <= 1'b0;
    seed_wr_data <= word_t'($urandom());
  endtask

  initial begin
    word_t clamp_seed;
    word_t x_last;
    int per_phase;
    bit found;

    // Seed whose first draw after a refill lands on a value above the clamp:
    // put value v at fill step k and require the slot picked by the final
    // fill value to be exactly the slot that holds step k.
    clamp_seed = word_t'(1);
    found = 1'b0;
    for (word_t v = SAMPLE_MAX + 1; v < LCG_MOD && !found; v++) begin
      for (int k = WARMUP + 1; k <= FILL_STEPS && !found; k++) begin
        x_last = lehmer_jump(v, longint'(FILL_STEPS - k));
        if (int'(x_last / SLOT_SPAN) == FILL_STEPS - k) begin
          clamp_seed = lehmer_jump(v, MOD64 - 1 - longint'(k));
          found = 1'b1;
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset seed; first request fills the table even without reseed
    pending_reseeds = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    wait_idle();

    // Zero seed behaves as one
    write_seed('0);
    pending_reseeds = '{1'b1, 1'b0, 1'b0};
    wait_idle();

    // Seed equal to the modulus behaves as one
    write_seed(LCG_MOD);
    pending_reseeds = '{1'b1, 1'b0, 1'b0};
    wait_idle();

    // Largest legal seed
    write_seed(LCG_MOD - 1);
    pending_reseeds = '{1'b1, 1'b0, 1'b0, 1'b1};
    wait_idle();

    // Output clamp
    write_seed(clamp_seed);
    pending_reseeds = '{1'b1, 1'b0, 1'b0};
    wait_idle();

    // Random phases: each starts with a refill from a fresh seed
    per_phase = RANDOM_ITEMS / RANDOM_PHASES;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_seed(word_t'(1));
        1: write_seed(LCG_MOD - 1);
        2: write_seed(word_t'($urandom_range(0, 1000)));
        default: write_seed(word_t'($urandom()));
      endcase
      pending_reseeds.push_back(1'b1);
      for (int i = 1; i < per_phase; i++)
        pending_reseeds.push_back($urandom_range(0, 15) == 0);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && predicted_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
